### rtl/core/bpur_pkg.sv
// shared types and constants for the bitmap pixel unpack and rotate block
`default_nettype none

package bpur_pkg;

  // coordinate fields are 12 bits, so the largest image side is 4096
  localparam int COORD_W       = 12;
  localparam int MAX_DIM       = 4096;
  localparam int DIM_CFG_W     = 13;
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  localparam int RGB_W         = 24;
  localparam int SCREEN_W      = 17;
  localparam int ORIGIN_W      = 16;

  localparam int IN_TDATA_W    = 88;
  localparam int OUT_TDATA_W   = 64;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_DEPTH_CODE    = 3'd2,
    REG_BOTTOM_UP     = 3'd3,
    REG_MIRROR_ENABLE = 3'd4,
    REG_QUARTER_TURNS = 3'd5,
    REG_ORIGIN_X      = 3'd6,
    REG_ORIGIN_Y      = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DEPTH_1BPP  = 3'd0,
    DEPTH_4BPP  = 3'd1,
    DEPTH_8BPP  = 3'd2,
    DEPTH_24BPP = 3'd3,
    DEPTH_32BPP = 3'd4
  } depth_code_t;

  typedef enum logic [1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turns_t;

  // where the color of a pixel comes from
  typedef enum logic [1:0] {
    COLOR_PALETTE = 2'd0,
    COLOR_DIRECT  = 2'd1,
    COLOR_BLACK   = 2'd2
  } color_src_t;

  typedef enum logic {
    OP_PIXEL     = 1'b0,
    OP_PAL_WRITE = 1'b1
  } op_t;

  // image side minus one, with 0 taken as 1 and anything above the max as the max
  function automatic logic [COORD_W-1:0] dim_minus_one(input logic [DIM_CFG_W-1:0] dim);
    logic [COORD_W-1:0] res;
    if (dim == '0) begin
      res = '0;
    end else if (dim > DIM_CFG_W'(MAX_DIM)) begin
      res = COORD_W'(MAX_DIM - 1);
    end else begin
      res = COORD_W'(dim - DIM_CFG_W'(1));
    end
    return res;
  endfunction

endpackage : bpur_pkg

`default_nettype wire

### rtl/core/bitmap_pixel_unpack_rotate.sv
// top level: bitmap pixel decode with palette, mirror, rotation and origin offset
`default_nettype none

//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------------
//  in_      | in        | in_tvalid / in_tready  | in_tdata: column, stored_row, pixel_bytes,
//           |           |                        |   palette_index, palette_red/green/blue
//           |           |                        | in_tuser: operation
//  out_     | out       | out_tvalid / out_tready| out_tdata: screen_x, screen_y, red, green, blue
//  cfg_     | in        | cfg_we                 | cfg_index, cfg_data
//
//  one item per clock while out_ does not stall; a pixel item passes the palette read
//  register, then the result register, on its way to out_tvalid
//  the palette is a 256 x 24 single-port-write memory read once per pixel item
//  a palette write item is taken without entering the pipeline and produces no result
//  rst_n is synchronous, active low; the palette holds no reset and is not cleared
//  a stall on out_ backs up through the two stages; in_tready drops only when both are full

module bitmap_pixel_unpack_rotate (
  input  wire logic                               clk,
  input  wire logic                               rst_n,

  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // [11:0] column, [23:12] stored_row, [55:24] pixel_bytes, [63:56] palette_index,
  // [71:64] palette_red, [79:72] palette_green, [87:80] palette_blue
  input  wire logic [bpur_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] operation
  input  wire logic                               in_tuser,

  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // [16:0] screen_x, [33:17] screen_y, [41:34] red, [49:42] green, [57:50] blue,
  // [63:58] zero
  output      logic [bpur_pkg::OUT_TDATA_W-1:0]  out_tdata,

  input  wire logic                               cfg_we,
  input  wire logic [bpur_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bpur_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import bpur_pkg::*;

  // ---------------------------------------------------------------- configuration
  logic [DIM_CFG_W-1:0]       image_width_r;
  logic [DIM_CFG_W-1:0]       image_height_r;
  logic [2:0]                 depth_code_r;
  logic                       bottom_up_r;
  logic                       mirror_enable_r;
  logic [1:0]                 quarter_turns_r;
  logic signed [ORIGIN_W-1:0] origin_x_r;
  logic signed [ORIGIN_W-1:0] origin_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= DIM_CFG_W'(1);
      image_height_r  <= DIM_CFG_W'(1);
      depth_code_r    <= DEPTH_24BPP;
      bottom_up_r     <= 1'b1;
      mirror_enable_r <= 1'b0;
      quarter_turns_r <= TURN_0;
      origin_x_r      <= '0;
      origin_y_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   image_width_r   <= cfg_data[DIM_CFG_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_r  <= cfg_data[DIM_CFG_W-1:0];
        REG_DEPTH_CODE:    depth_code_r    <= cfg_data[2:0];
        REG_BOTTOM_UP:     bottom_up_r     <= cfg_data[0];
        REG_MIRROR_ENABLE: mirror_enable_r <= cfg_data[0];
        REG_QUARTER_TURNS: quarter_turns_r <= cfg_data[1:0];
        REG_ORIGIN_X:      origin_x_r      <= signed'(cfg_data);
        REG_ORIGIN_Y:      origin_y_r      <= signed'(cfg_data);
        default:           ;
      endcase
    end
  end

  // clamped sides minus one, shared by both stages; config is to move only while idle, the block does not enforce it
  logic [COORD_W-1:0] w_m1;
  logic [COORD_W-1:0] h_m1;

  assign w_m1 = dim_minus_one(image_width_r);
  assign h_m1 = dim_minus_one(image_height_r);

  // ---------------------------------------------------------------- input unpack
  logic [COORD_W-1:0] in_column;
  logic [COORD_W-1:0] in_row;
  logic [31:0]        in_bytes;
  logic [7:0]         in_pal_index;
  logic [RGB_W-1:0]   in_pal_rgb;

  assign in_column    = in_tdata[11:0];
  assign in_row       = in_tdata[23:12];
  assign in_bytes     = in_tdata[55:24];
  assign in_pal_index = in_tdata[63:56];
  // stored as red high, blue low
  assign in_pal_rgb   = {in_tdata[71:64], in_tdata[79:72], in_tdata[87:80]};

  // ---------------------------------------------------------------- handshake
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic s1_advance;
  logic in_accept;
  logic pix_accept;
  logic pal_accept;

  assign s1_advance = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_accept  = in_tvalid && in_tready;
  assign pix_accept = in_accept && (op_t'(in_tuser) == OP_PIXEL);
  assign pal_accept = in_accept && (op_t'(in_tuser) == OP_PAL_WRITE);

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_advance) begin
      out_valid_nxt = s1_valid_r;
    end
    if (in_tready) begin
      s1_valid_nxt = pix_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 1: clamp, index
  logic [COORD_W-1:0] col_c;
  logic [COORD_W-1:0] row_c;
  logic [7:0]         b0;
  logic [PAL_AW-1:0]  pix_index;
  color_src_t         color_src;

  assign col_c = (in_column > w_m1) ? w_m1 : in_column;
  assign row_c = (in_row > h_m1) ? h_m1 : in_row;
  assign b0    = in_bytes[7:0];

  always_comb begin
    pix_index = '0;
    color_src = COLOR_BLACK;
    case (depth_code_t'(depth_code_r))
      DEPTH_1BPP: begin
        // msb first within the byte
        pix_index = PAL_AW'(b0[3'd7 - col_c[2:0]]);
        color_src = COLOR_PALETTE;
      end
      DEPTH_4BPP: begin
        // even columns sit in the high nibble
        pix_index = col_c[0] ? PAL_AW'(b0[3:0]) : PAL_AW'(b0[7:4]);
        color_src = COLOR_PALETTE;
      end
      DEPTH_8BPP: begin
        pix_index = PAL_AW'(b0);
        color_src = COLOR_PALETTE;
      end
      DEPTH_24BPP, DEPTH_32BPP: begin
        color_src = COLOR_DIRECT;
      end
      default: begin
        color_src = COLOR_BLACK;
      end
    endcase
  end

  logic [RGB_W-1:0]   palette_mem [PALETTE_DEPTH];
  logic [RGB_W-1:0]   pal_q_r;
  logic [COORD_W-1:0] s1_col_r;
  logic [COORD_W-1:0] s1_row_r;
  logic [RGB_W-1:0]   s1_bgr_r;
  color_src_t         s1_src_r;

  always_ff @(posedge clk) begin
    if (pal_accept) begin
      palette_mem[in_pal_index[PAL_AW-1:0]] <= in_pal_rgb;
    end
    if (pix_accept) begin
      pal_q_r  <= palette_mem[pix_index];
      s1_col_r <= col_c;
      s1_row_r <= row_c;
      s1_bgr_r <= in_bytes[23:0];
      s1_src_r <= color_src;
    end
  end

  // ---------------------------------------------------------------- stage 2: color, geometry
  logic [7:0]          red_nxt;
  logic [7:0]          green_nxt;
  logic [7:0]          blue_nxt;
  logic [COORD_W-1:0]  x_img;
  logic [COORD_W-1:0]  y_img;
  logic [COORD_W-1:0]  rx;
  logic [COORD_W-1:0]  ry;
  logic [SCREEN_W-1:0] screen_x_nxt;
  logic [SCREEN_W-1:0] screen_y_nxt;

  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    case (s1_src_r)
      COLOR_PALETTE: begin
        red_nxt   = pal_q_r[23:16];
        green_nxt = pal_q_r[15:8];
        blue_nxt  = pal_q_r[7:0];
      end
      COLOR_DIRECT: begin
        // stored order is b, g, r from byte 0 up
        blue_nxt  = s1_bgr_r[7:0];
        green_nxt = s1_bgr_r[15:8];
        red_nxt   = s1_bgr_r[23:16];
      end
      default: ;
    endcase
  end

  assign y_img = bottom_up_r ? (h_m1 - s1_row_r) : s1_row_r;
  assign x_img = mirror_enable_r ? (w_m1 - s1_col_r) : s1_col_r;

  always_comb begin
    case (turns_t'(quarter_turns_r))
      TURN_90: begin
        rx = h_m1 - y_img;
        ry = x_img;
      end
      TURN_180: begin
        rx = w_m1 - x_img;
        ry = h_m1 - y_img;
      end
      TURN_270: begin
        rx = y_img;
        ry = w_m1 - x_img;
      end
      default: begin
        rx = x_img;
        ry = y_img;
      end
    endcase
  end

  // wraps to 17 bits
  assign screen_x_nxt = SCREEN_W'(origin_x_r) + SCREEN_W'(rx);
  assign screen_y_nxt = SCREEN_W'(origin_y_r) + SCREEN_W'(ry);

  logic [SCREEN_W-1:0] screen_x_r;
  logic [SCREEN_W-1:0] screen_y_r;
  logic [7:0]          red_r;
  logic [7:0]          green_r;
  logic [7:0]          blue_r;

  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid_r) begin
      screen_x_r <= screen_x_nxt;
      screen_y_r <= screen_y_nxt;
      red_r      <= red_nxt;
      green_r    <= green_nxt;
      blue_r     <= blue_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, blue_r, green_r, red_r, screen_y_r, screen_x_r};

  // ---------------------------------------------------------------- checks
  // a palette write never occupies the pixel stage
  a_pal_no_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> !s1_valid_r)
    else $error("palette write left an item in stage 1");

  // a pixel item always lands in stage 1
  a_pix_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> s1_valid_r)
    else $error("accepted pixel item lost");

  // a stage 1 item moving on shows up as a result
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_advance) |=> out_valid_r)
    else $error("stage 1 item did not reach the result register");

  // back-pressure only when both stages are full and the sink stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule : bitmap_pixel_unpack_rotate

`default_nettype wire

### dv/tb.sv
// self-checking testbench for the bitmap pixel unpack and rotate block
`default_nettype none

module tb;
  import bpur_pkg::*;

  // run length and drain settings
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 4;   // two pipeline stages plus margin
  localparam int MAX_REPORTS  = 10;

  // one input item, fields as the block sees them
  typedef struct packed {
    op_t         op;
    logic [11:0] col;
    logic [11:0] srow;
    logic [31:0] bytes;
    logic [7:0]  pidx;
    logic [7:0]  pr;
    logic [7:0]  pg;
    logic [7:0]  pb;
  } in_item_t;

  // one screen point
  typedef struct packed {
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
  } point_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  // directed stimulus row: either a register write or an item,
  // with an optional hand-written expected point
  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    sel;
    logic [15:0] val;
    in_item_t    it;
    bit          typed;
    point_t      want;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bitmap_pixel_unpack_rotate DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow copy of the block's registers and palette
  logic [12:0]        cfg_width     = 13'd1;
  logic [12:0]        cfg_height    = 13'd1;
  logic [2:0]         cfg_depth     = DEPTH_24BPP;
  logic               cfg_bottom_up = 1'b1;
  logic               cfg_mirror    = 1'b0;
  turns_t             cfg_turns     = TURN_0;
  logic signed [15:0] cfg_ox        = '0;
  logic signed [15:0] cfg_oy        = '0;
  logic [23:0]        pal_mem [PALETTE_DEPTH];
  bit                 pal_written [PALETTE_DEPTH];

  point_t    pending_points[$];
  stim_row_t stim_rows[$];

  int  items_sent;
  int  pixels_sent;
  int  pal_loads;
  int  settings_used;
  int  points_checked;
  int  fail_count;
  int  cycle_cnt;
  bit  tx_burst;
  bit  rx_burst;

  // 12 time unit clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // zero acts as one, anything above the max side as the max side
  function automatic int eff_dim(logic [12:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  // palette index for the low-depth modes, taken at the clamped column;
  // 1 bpp is msb first, 4 bpp uses the high nibble on even columns
  function automatic logic [7:0] pal_index(logic [11:0] col, logic [31:0] bytes);
    int         c;
    logic [7:0] b0;
    c  = (col > eff_dim(cfg_width) - 1) ? eff_dim(cfg_width) - 1 : col;
    b0 = bytes[7:0];
    case (cfg_depth)
      DEPTH_1BPP: return {7'd0, b0[7 - (c % 8)]};
      DEPTH_4BPP: return (c % 2) ? {4'd0, b0[3:0]} : {4'd0, b0[7:4]};
      default:    return b0;
    endcase
  endfunction

  // screen point for a pixel item under the current register settings
  function automatic point_t decode_point(logic [11:0] col, logic [11:0] srow,
                                          logic [31:0] bytes);
    point_t      p;
    int          w, h, c, rw, x, y, rx, ry;
    logic [23:0] rgb;
    w  = eff_dim(cfg_width);
    h  = eff_dim(cfg_height);
    c  = (col > w - 1) ? w - 1 : col;
    rw = (srow > h - 1) ? h - 1 : srow;
    case (cfg_depth)
      DEPTH_1BPP, DEPTH_4BPP, DEPTH_8BPP: rgb = pal_mem[pal_index(col, bytes)];
      DEPTH_24BPP, DEPTH_32BPP:           rgb = bytes[23:0];  // byte 2 red, byte 0 blue
      default:                            rgb = '0;           // unknown depth gives black
    endcase
    y = cfg_bottom_up ? h - 1 - rw : rw;
    x = cfg_mirror ? w - 1 - c : c;
    case (cfg_turns)
      TURN_90: begin
        rx = h - 1 - y;
        ry = x;
      end
      TURN_180: begin
        rx = w - 1 - x;
        ry = h - 1 - y;
      end
      TURN_270: begin
        rx = y;
        ry = w - 1 - x;
      end
      default: begin
        rx = x;
        ry = y;
      end
    endcase
    // origin add wraps to the 17-bit output
    p.sx = 17'(int'(cfg_ox) + rx);
    p.sy = 17'(int'(cfg_oy) + ry);
    {p.r, p.g, p.b} = rgb;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // directed rows
  // ---------------------------------------------------------------------------

  function automatic void add_cfg(cfg_reg_t sel, int val);
    stim_row_t s;
    s.kind  = ROW_CFG;
    s.sel   = sel;
    s.val   = 16'(val);
    s.it    = '0;
    s.typed = 1'b0;
    s.want  = '0;
    stim_rows.push_back(s);
  endfunction

  function automatic void add_pal(int idx, logic [23:0] rgb);
    stim_row_t s;
    s.kind            = ROW_ITEM;
    s.sel             = REG_IMAGE_WIDTH;
    s.val             = '0;
    s.it              = '0;
    s.it.op           = OP_PAL_WRITE;
    s.it.pidx         = 8'(idx);
    {s.it.pr, s.it.pg, s.it.pb} = rgb;
    s.typed           = 1'b0;
    s.want            = '0;
    stim_rows.push_back(s);
  endfunction

  function automatic void add_pix(int col, int srow, logic [31:0] bytes);
    stim_row_t s;
    s.kind     = ROW_ITEM;
    s.sel      = REG_IMAGE_WIDTH;
    s.val      = '0;
    s.it       = '0;
    s.it.op    = OP_PIXEL;
    s.it.col   = 12'(col);
    s.it.srow  = 12'(srow);
    s.it.bytes = bytes;
    s.typed    = 1'b0;
    s.want     = '0;
    stim_rows.push_back(s);
  endfunction

  // pixel row whose point is written out by hand
  function automatic void add_pix_exp(int col, int srow, logic [31:0] bytes,
                                      int x, int y, logic [23:0] rgb);
    add_pix(col, srow, bytes);
    stim_rows[$].typed   = 1'b1;
    stim_rows[$].want.sx = 17'(x);
    stim_rows[$].want.sy = 17'(y);
    {stim_rows[$].want.r, stim_rows[$].want.g, stim_rows[$].want.b} = rgb;
  endfunction

  function automatic void build_directed();
    // reset settings: 1x1 image, 24 bpp, bottom-up; everything clamps to 0,0
    add_pix_exp(4095, 4095, 32'hFFFF_FFFF, 0, 0, 24'hFFFFFF);
    add_pix_exp(0, 0, 32'h0012_3456, 0, 0, 24'h123456);
    // largest image, 32 bpp, top-down, origin at both extremes
    add_cfg(REG_IMAGE_WIDTH, 4096);
    add_cfg(REG_IMAGE_HEIGHT, 4096);
    add_cfg(REG_BOTTOM_UP, 0);
    add_cfg(REG_DEPTH_CODE, DEPTH_32BPP);
    add_cfg(REG_ORIGIN_X, 16'h7FFF);
    add_cfg(REG_ORIGIN_Y, 16'h8000);
    add_pix_exp(4095, 4095, 32'hA5C3_E1F0, 32767 + 4095, -32768 + 4095, 24'hC3E1F0);
    add_pix_exp(0, 0, 32'h0000_0000, 32767, -32768, 24'h000000);
    // out-of-range sides, mirror and each nonzero rotation
    add_cfg(REG_IMAGE_WIDTH, 13'h1FFF);
    add_cfg(REG_IMAGE_HEIGHT, 0);
    add_cfg(REG_MIRROR_ENABLE, 1);
    add_cfg(REG_QUARTER_TURNS, TURN_90);
    add_cfg(REG_BOTTOM_UP, 1);
    add_cfg(REG_ORIGIN_X, 0);
    add_cfg(REG_ORIGIN_Y, 0);
    add_pix(5, 7, 32'h00FF_8040);
    add_cfg(REG_QUARTER_TURNS, TURN_180);
    add_pix(4000, 100, 32'h55AA_33CC);
    add_cfg(REG_QUARTER_TURNS, TURN_270);
    add_pix(1, 4095, 32'h0ACE_1234);
    // 1 bpp: msb belongs to column 0, lsb to column 7
    add_cfg(REG_IMAGE_WIDTH, 16);
    add_cfg(REG_IMAGE_HEIGHT, 16);
    add_cfg(REG_MIRROR_ENABLE, 0);
    add_cfg(REG_QUARTER_TURNS, TURN_0);
    add_cfg(REG_DEPTH_CODE, DEPTH_1BPP);
    add_pal(0, 24'h112233);
    add_pal(1, 24'h445566);
    add_pix_exp(0, 0, 32'h0000_0080, 0, 15, 24'h445566);
    add_pix(7, 2, 32'h0000_0080);
    add_pix(7, 2, 32'h0000_0001);
    // 4 bpp: high nibble for even columns
    add_cfg(REG_DEPTH_CODE, DEPTH_4BPP);
    add_pal(15, 24'hABCDEF);
    add_pix(0, 3, 32'h0000_00F0);
    add_pix(1, 3, 32'h0000_00F0);
    // 8 bpp, top index, column clamp
    add_cfg(REG_DEPTH_CODE, DEPTH_8BPP);
    add_pal(255, 24'hFFFFFF);
    add_pal(128, 24'h010203);
    add_pix(2, 2, 32'hFFFF_FFFF);
    add_pix(20, 20, 32'h0000_0080);
    // undefined depth codes give a black point
    add_cfg(REG_DEPTH_CODE, 5);
    add_pix_exp(3, 4, 32'hFFFF_FFFF, 3, 11, 24'h000000);
    add_cfg(REG_DEPTH_CODE, 7);
    add_pix(9, 9, 32'h1234_5678);
    // overwrite a palette entry and read it back
    add_pal(0, 24'h000000);
    add_cfg(REG_DEPTH_CODE, DEPTH_1BPP);
    add_pix(0, 0, 32'h0000_0000);
  endfunction

  // ---------------------------------------------------------------------------
  // random stimulus
  // ---------------------------------------------------------------------------

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return MAX_DIM;
      3:       return 13'h1FFF;
      4:       return $urandom_range(MAX_DIM + 1, 8191);
      5, 6:    return $urandom_range(2, 64);
      default: return $urandom_range(1, MAX_DIM);
    endcase
  endfunction

  function automatic int pick_origin();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 0;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // mostly inside the image, sometimes at the edges or anywhere in 12 bits
  function automatic logic [11:0] pick_coord(int side);
    case ($urandom_range(0, 7))
      0:       return 12'd0;
      1:       return 12'(side - 1);
      2:       return 12'd4095;
      3, 4:    return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(0, side - 1));
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.op    = ($urandom_range(0, 4) == 0) ? OP_PAL_WRITE : OP_PIXEL;
    it.col   = pick_coord(eff_dim(cfg_width) > 4096 ? 4096 : eff_dim(cfg_width));
    it.srow  = pick_coord(eff_dim(cfg_height) > 4096 ? 4096 : eff_dim(cfg_height));
    it.bytes = $urandom;
    it.pidx  = 8'($urandom);
    it.pr    = 8'($urandom);
    it.pg    = 8'($urandom);
    it.pb    = 8'($urandom);
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // register write with the channel idle; shadow copy follows at the same edge
  task automatic write_reg(cfg_reg_t sel, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    case (sel)
      REG_IMAGE_WIDTH:   cfg_width     = val[12:0];
      REG_IMAGE_HEIGHT:  cfg_height    = val[12:0];
      REG_DEPTH_CODE:    cfg_depth     = val[2:0];
      REG_BOTTOM_UP:     cfg_bottom_up = val[0];
      REG_MIRROR_ENABLE: cfg_mirror    = val[0];
      REG_QUARTER_TURNS: cfg_turns     = turns_t'(val[1:0]);
      REG_ORIGIN_X:      cfg_ox        = val;
      REG_ORIGIN_Y:      cfg_oy        = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold the input side until every point is out, then let palette writes settle
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // present one item after a random gap and track it once accepted
  task automatic drive_item(in_item_t it, bit typed, point_t want);
    int gap;
    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.pb, it.pg, it.pr, it.pidx, it.bytes, it.srow, it.col};
    in_tuser  <= it.op;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (it.op == OP_PAL_WRITE) begin
      pal_mem[it.pidx]     = {it.pr, it.pg, it.pb};
      pal_written[it.pidx] = 1'b1;
      pal_loads++;
    end else begin
      pending_points.push_back(typed ? want : decode_point(it.col, it.srow, it.bytes));
      pixels_sent++;
    end
  endtask

  // a pixel that would read a never-loaded palette entry gets that entry loaded first
  task automatic send_item(in_item_t it, bit typed, point_t want);
    in_item_t fill;
    logic [7:0] idx;
    idx = pal_index(it.col, it.bytes);
    if (it.op == OP_PIXEL && cfg_depth <= DEPTH_8BPP && !pal_written[idx]) begin
      fill      = random_item();
      fill.op   = OP_PAL_WRITE;
      fill.pidx = idx;
      drive_item(fill, 1'b0, '0);
    end
    drive_item(it, typed, want);
  endtask

  task automatic randomize_config();
    int d;
    d = $urandom_range(0, 5);
    if (d == 5) d = $urandom_range(5, 7);   // undefined depth now and then
    write_reg(REG_IMAGE_WIDTH, 16'(pick_dim()));
    write_reg(REG_IMAGE_HEIGHT, 16'(pick_dim()));
    write_reg(REG_DEPTH_CODE, 16'(d));
    write_reg(REG_BOTTOM_UP, 16'($urandom_range(0, 1)));
    write_reg(REG_MIRROR_ENABLE, 16'($urandom_range(0, 1)));
    write_reg(REG_QUARTER_TURNS, 16'($urandom_range(0, 3)));
    write_reg(REG_ORIGIN_X, 16'(pick_origin()));
    write_reg(REG_ORIGIN_Y, 16'(pick_origin()));
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, then compare each point in order
  // ---------------------------------------------------------------------------

  initial begin
    int stall;
    out_tready = 1'b0;
    rx_burst   = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    point_t want;
    point_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.sx = out_tdata[16:0];
      got.sy = out_tdata[33:17];
      got.r  = out_tdata[41:34];
      got.g  = out_tdata[49:42];
      got.b  = out_tdata[57:50];
      if (pending_points.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("cycle %0d: point x=%0d y=%0d with nothing pending",
                   cycle_cnt, got.sx, got.sy);
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (got.sx !== want.sx || got.sy !== want.sy || got.r !== want.r ||
            got.g !== want.g || got.b !== want.b || out_tdata[63:58] !== '0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("cycle %0d: expected x=%0d y=%0d rgb=%h%h%h, got x=%0d y=%0d rgb=%h%h%h pad=%h",
                     cycle_cnt, want.sx, want.sy, want.r, want.g, want.b,
                     got.sx, got.sy, got.r, got.g, got.b, out_tdata[63:58]);
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d points still pending",
             cycle_cnt, pending_points.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int phase;
    int len;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    tx_burst  = 1'b0;
    foreach (pal_written[i]) pal_written[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows; every register write waits for the block to go idle
    build_directed();
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(stim_rows[i].sel, stim_rows[i].val);
      end else begin
        send_item(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].want);
      end
    end
    settings_used++;

    // random phases, each under a fresh set of registers
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain_results();
      randomize_config();
      len = $urandom_range(30, 90);
      for (int i = 0; i < len && items_sent < RANDOM_ITEMS; i++) begin
        // one phase stops the sender mid-stream until the pipe is empty
        if (phase == 3 && i == len / 2) drain_results();
        send_item(random_item(), 1'b0, '0);
      end
      phase++;
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("drove %0d items: %0d pixels and %0d palette loads under %0d register settings",
             items_sent, pixels_sent, pal_loads, settings_used);
    $display("compared %0d screen points, %0d failures", points_checked, fail_count);
    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

### bitmap_pixel_unpack_rotate.f
rtl/core/bpur_pkg.sv
rtl/core/bitmap_pixel_unpack_rotate.sv
dv/tb.sv
